### src/ssmix_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssmix_pkg
// Shared types and constants for the scheduled stereo sample mixer.
// ----------------------------------------------------------------------------
package ssmix_pkg;

	localparam int MAX_SLOTS_DEF   = 16;
	localparam int PEND_DEPTH_DEF  = 8;
	localparam int STORE_WORDS_DEF = 65536;
	localparam int RETIRE_LIMIT    = 16;

	typedef enum logic [1:0] {
		FUNC_WRITE    = 2'd0,
		FUNC_SCHEDULE = 2'd1,
		FUNC_BLOCK    = 2'd2,
		FUNC_TICK     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_ID     = 2'd0,
		KIND_DONE   = 2'd1,
		KIND_MIX    = 2'd2,
		KIND_FULL   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RET_RD,
		ST_RET_CHK,
		ST_RET_OUT,
		ST_RET_LAST,
		ST_ADMIT,
		ST_MIX_RD,
		ST_MIX_MEM,
		ST_MIX_ACC,
		ST_MIX_OUT,
		ST_RESP
	} state_t;

	// signed saturation of an accumulator to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
		logic signed [15:0] r;
		if (v > 24'sd32767) r = 16'sh7fff;
		else if (v < -24'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### src/scheduled_stereo_sample_mixer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scheduled_stereo_sample_mixer_unit
// Stereo mixer playing scheduled sounds from an on-chip sample memory.
// ----------------------------------------------------------------------------
// a write stores in the idle state; a tick reads, fetches and adds each used slot,
// a block start retires finished slots, then admits queued sounds into free slots
// one transaction in flight; the next is taken once the sequencer is idle again
// results wait in an output register while out_stall is high
// arst_n clears slot count, queue pointers, time, id counter and control
module scheduled_stereo_sample_mixer_unit #(
	parameter int MAX_SLOTS   = ssmix_pkg::MAX_SLOTS_DEF,
	parameter int PEND_DEPTH  = ssmix_pkg::PEND_DEPTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire  [1:0]        func,
	input  wire  [15:0]       address,
	input  wire signed [15:0] in_left,
	input  wire signed [15:0] in_right,
	input  wire  [16:0]       sound_length,
	input  wire  [31:0]       start_time,
	input  wire               use_now,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [1:0]        kind,
	output logic [31:0]       play_id,
	output logic signed [15:0] mix_left,
	output logic signed [15:0] mix_right,
	output logic              last
);
	localparam int STORE_WORDS = ssmix_pkg::STORE_WORDS_DEF;
	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int PW = $clog2(PEND_DEPTH);
	localparam int QW = $clog2(PEND_DEPTH + 1);
	localparam int AW = $clog2(STORE_WORDS);
	localparam int RW = $clog2(ssmix_pkg::RETIRE_LIMIT + 1);

	logic [31:0] store_q [STORE_WORDS];
	logic [31:0] rd_word_q;
	logic [AW-1:0] rd_addr;
	logic rd_en;

	logic [31:0] sl_start_q [MAX_SLOTS];
	logic [15:0] sl_base_q  [MAX_SLOTS];
	logic [16:0] sl_len_q   [MAX_SLOTS];
	logic [31:0] sl_id_q    [MAX_SLOTS];
	logic [31:0] pd_start_q [PEND_DEPTH];
	logic [15:0] pd_base_q  [PEND_DEPTH];
	logic [16:0] pd_len_q   [PEND_DEPTH];
	logic [31:0] pd_id_q    [PEND_DEPTH];

	ssmix_pkg::state_t st_q, st_d;
	logic [CW-1:0] used_q;
	logic [PW-1:0] head_q;
	logic [QW-1:0] cnt_q;
	logic [31:0] now_q, idc_q;
	logic [CW-1:0] idx_q;
	logic [RW-1:0] nret_q;
	logic [31:0] cs_q, cid_q;
	logic [15:0] cb_q;
	logic [16:0] cl_q;
	logic signed [23:0] accl_q, accr_q;
	logic act_q;
	logic hold_v_q;
	logic [31:0] hold_id_q;

	logic [15:0] addr_q;
	logic [16:0] len_q;
	logic [31:0] st_time_q;
	logic use_q;

	logic [SW-1:0] ix;
	logic [SW-1:0] lastix;
	logic [QW:0] wsum;
	logic [PW-1:0] wslot;
	logic [31:0] elapsed;
	logic over, playing;
	logic [31:0] nid1;
	logic acc_in, out_go, out_load;

	assign ix = idx_q[SW-1:0];
	assign lastix = SW'(used_q - CW'(1));
	assign wsum = (QW+1)'(head_q) + (QW+1)'(cnt_q);
	assign wslot = (wsum >= (QW+1)'(PEND_DEPTH)) ? PW'(wsum - (QW+1)'(PEND_DEPTH)) :
		PW'(wsum);
	// shared subtract/compare unit
	assign elapsed = now_q - cs_q;
	assign over = !elapsed[31] && (elapsed >= {15'd0, cl_q});
	assign playing = !elapsed[31] && (elapsed < {15'd0, cl_q});
	assign nid1 = idc_q + 32'd1;

	assign in_stall = (st_q != ssmix_pkg::ST_IDLE);
	assign acc_in = in_valid && !in_stall;
	assign out_go = !out_valid || !out_stall;
	assign out_load = out_go && (st_q == ssmix_pkg::ST_RET_OUT ||
		st_q == ssmix_pkg::ST_RET_LAST || st_q == ssmix_pkg::ST_MIX_OUT ||
		st_q == ssmix_pkg::ST_RESP);

	assign rd_addr = AW'({16'd0, cb_q} + elapsed);
	assign rd_en = (st_q == ssmix_pkg::ST_MIX_MEM);

	always_ff @(posedge clk) begin
		if (acc_in && ssmix_pkg::func_t'(func) == ssmix_pkg::FUNC_WRITE)
			store_q[AW'(address)] <= {in_right, in_left};
		if (rd_en)
			rd_word_q <= store_q[rd_addr];
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ssmix_pkg::ST_IDLE: begin
				if (acc_in) begin
					unique case (ssmix_pkg::func_t'(func))
						ssmix_pkg::FUNC_WRITE:    st_d = ssmix_pkg::ST_IDLE;
						ssmix_pkg::FUNC_SCHEDULE: st_d = ssmix_pkg::ST_RESP;
						ssmix_pkg::FUNC_BLOCK:    st_d = ssmix_pkg::ST_RET_RD;
						ssmix_pkg::FUNC_TICK:     st_d = ssmix_pkg::ST_MIX_RD;
					endcase
				end
			end
			ssmix_pkg::ST_RET_RD: begin
				if (idx_q == '0 || nret_q == RW'(ssmix_pkg::RETIRE_LIMIT))
					st_d = hold_v_q ? ssmix_pkg::ST_RET_LAST : ssmix_pkg::ST_ADMIT;
				else
					st_d = ssmix_pkg::ST_RET_CHK;
			end
			ssmix_pkg::ST_RET_CHK: begin
				if (over && hold_v_q) st_d = ssmix_pkg::ST_RET_OUT;
				else st_d = ssmix_pkg::ST_RET_RD;
			end
			ssmix_pkg::ST_RET_OUT:  if (out_go) st_d = ssmix_pkg::ST_RET_RD;
			ssmix_pkg::ST_RET_LAST: if (out_go) st_d = ssmix_pkg::ST_ADMIT;
			ssmix_pkg::ST_ADMIT: begin
				if (cnt_q == '0 || used_q == CW'(MAX_SLOTS)) begin
					st_d = ssmix_pkg::ST_IDLE;
				end
			end
			ssmix_pkg::ST_MIX_RD:
				st_d = (idx_q == used_q) ? ssmix_pkg::ST_MIX_OUT : ssmix_pkg::ST_MIX_MEM;
			ssmix_pkg::ST_MIX_MEM: st_d = ssmix_pkg::ST_MIX_ACC;
			ssmix_pkg::ST_MIX_ACC: st_d = ssmix_pkg::ST_MIX_RD;
			ssmix_pkg::ST_MIX_OUT: if (out_go) st_d = ssmix_pkg::ST_IDLE;
			ssmix_pkg::ST_RESP:    if (out_go) st_d = ssmix_pkg::ST_IDLE;
			default: st_d = ssmix_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ssmix_pkg::ST_IDLE;
			used_q <= '0;
			head_q <= '0;
			cnt_q <= '0;
			now_q <= '0;
			idc_q <= '0;
			idx_q <= '0;
			nret_q <= '0;
			out_valid <= 1'b0;
			last <= 1'b0;
			act_q <= 1'b0;
			hold_v_q <= 1'b0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				sl_start_q[i] <= '0;
				sl_base_q[i] <= '0;
				sl_len_q[i] <= '0;
				sl_id_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (st_q)
				ssmix_pkg::ST_IDLE: begin
					if (acc_in) begin
						addr_q <= address;
						len_q <= sound_length;
						st_time_q <= start_time;
						use_q <= use_now;
						nret_q <= '0;
						accl_q <= '0;
						accr_q <= '0;
						idx_q <= (ssmix_pkg::func_t'(func) == ssmix_pkg::FUNC_BLOCK) ?
							used_q : '0;
					end
				end
				ssmix_pkg::ST_RET_RD: begin
					if (idx_q != '0 && nret_q != RW'(ssmix_pkg::RETIRE_LIMIT)) begin
						cs_q <= sl_start_q[SW'(idx_q - CW'(1))];
						cl_q <= sl_len_q[SW'(idx_q - CW'(1))];
						cid_q <= sl_id_q[SW'(idx_q - CW'(1))];
						idx_q <= idx_q - CW'(1);
					end
				end
				ssmix_pkg::ST_RET_CHK: begin
					if (over) begin
						sl_start_q[ix] <= sl_start_q[lastix];
						sl_base_q[ix] <= sl_base_q[lastix];
						sl_len_q[ix] <= sl_len_q[lastix];
						sl_id_q[ix] <= sl_id_q[lastix];
						used_q <= used_q - CW'(1);
						nret_q <= nret_q + RW'(1);
						if (!hold_v_q) begin
							hold_id_q <= cid_q;
							hold_v_q <= 1'b1;
						end
					end
				end
				ssmix_pkg::ST_RET_OUT: begin
					if (out_go) begin
						kind <= ssmix_pkg::KIND_DONE;
						play_id <= hold_id_q;
						mix_left <= '0;
						mix_right <= '0;
						last <= 1'b0;
						hold_id_q <= cid_q;
					end
				end
				ssmix_pkg::ST_RET_LAST: begin
					if (out_go) begin
						kind <= ssmix_pkg::KIND_DONE;
						play_id <= hold_id_q;
						mix_left <= '0;
						mix_right <= '0;
						last <= 1'b1;
						hold_v_q <= 1'b0;
					end
				end
				ssmix_pkg::ST_ADMIT: begin
					if (cnt_q != '0 && used_q != CW'(MAX_SLOTS)) begin
						sl_start_q[SW'(used_q)] <= pd_start_q[head_q];
						sl_base_q[SW'(used_q)] <= pd_base_q[head_q];
						sl_len_q[SW'(used_q)] <= pd_len_q[head_q];
						sl_id_q[SW'(used_q)] <= pd_id_q[head_q];
						used_q <= used_q + CW'(1);
						head_q <= (head_q == PW'(PEND_DEPTH - 1)) ? '0 : head_q + PW'(1);
						cnt_q <= cnt_q - QW'(1);
					end
				end
				ssmix_pkg::ST_MIX_RD: begin
					if (idx_q != used_q) begin
						cs_q <= sl_start_q[ix];
						cl_q <= sl_len_q[ix];
						cb_q <= sl_base_q[ix];
						idx_q <= idx_q + CW'(1);
					end
				end
				ssmix_pkg::ST_MIX_MEM: begin
					act_q <= playing;
				end
				ssmix_pkg::ST_MIX_ACC: begin
					if (act_q) begin
						accl_q <= accl_q + 24'(signed'(rd_word_q[15:0]));
						accr_q <= accr_q + 24'(signed'(rd_word_q[31:16]));
					end
					act_q <= 1'b0;
				end
				ssmix_pkg::ST_MIX_OUT: begin
					if (out_go) begin
						kind <= ssmix_pkg::KIND_MIX;
						play_id <= '0;
						mix_left <= ssmix_pkg::sat16(accl_q);
						mix_right <= ssmix_pkg::sat16(accr_q);
						last <= 1'b1;
						now_q <= now_q + 32'd1;
					end
				end
				ssmix_pkg::ST_RESP: begin
					if (out_go) begin
						mix_left <= '0;
						mix_right <= '0;
						last <= 1'b1;
						if (cnt_q >= QW'(PEND_DEPTH)) begin
							kind <= ssmix_pkg::KIND_FULL;
							play_id <= '0;
						end else begin
							kind <= ssmix_pkg::KIND_ID;
							play_id <= (nid1 == '0) ? 32'd1 : nid1;
							idc_q <= (nid1 == '0) ? 32'd1 : nid1;
							pd_start_q[wslot] <= use_q ? now_q : st_time_q;
							pd_base_q[wslot] <= addr_q;
							pd_len_q[wslot] <= len_q;
							pd_id_q[wslot] <= (nid1 == '0) ? 32'd1 : nid1;
							cnt_q <= cnt_q + QW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(play_id) &&
			$stable(mix_left) && $stable(mix_right) && $stable(last))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(MAX_SLOTS))
		else $error("slot count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QW'(PEND_DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == ssmix_pkg::KIND_ID |-> play_id != '0)
		else $error("zero play id");

endmodule
`default_nettype wire

### tb/sv/ssmix_checker.sv
// ----------------------------------------------------------------------------
// ssmix_checker
// Watches both channels of the stereo sample mixer, predicts the results of
// every accepted input transaction and compares them in order.
// ----------------------------------------------------------------------------
module ssmix_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_stall,
	input  wire  [1:0]        func,
	input  wire  [15:0]       address,
	input  wire signed [15:0] in_left,
	input  wire signed [15:0] in_right,
	input  wire  [16:0]       sound_length,
	input  wire  [31:0]       start_time,
	input  wire               use_now,
	input  wire               out_valid,
	input  wire               out_stall,
	input  wire  [1:0]        kind,
	input  wire  [31:0]       play_id,
	input  wire signed [15:0] mix_left,
	input  wire signed [15:0] mix_right,
	input  wire               last,
	output int                fail_count,
	output int                pending,
	output int                results_seen
);

	typedef struct packed {
		ssmix_pkg::kind_t   kind;
		logic [31:0]        play_id;
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               last;
	} mix_result_t;

	mix_result_t result_q[$];

	logic [31:0] samples [int];
	logic [31:0] ch_start [ssmix_pkg::MAX_SLOTS_DEF];
	logic [15:0] ch_base [ssmix_pkg::MAX_SLOTS_DEF];
	logic [16:0] ch_len [ssmix_pkg::MAX_SLOTS_DEF];
	logic [31:0] ch_id [ssmix_pkg::MAX_SLOTS_DEF];
	int          ch_used;
	logic [31:0] q_start [ssmix_pkg::PEND_DEPTH_DEF];
	logic [15:0] q_base [ssmix_pkg::PEND_DEPTH_DEF];
	logic [16:0] q_len [ssmix_pkg::PEND_DEPTH_DEF];
	logic [31:0] q_id [ssmix_pkg::PEND_DEPTH_DEF];
	int          q_head, q_count;
	logic [31:0] play_time, next_id;

	assign pending = result_q.size();

	function automatic mix_result_t mk(ssmix_pkg::kind_t k, logic [31:0] id,
			logic signed [15:0] l, logic signed [15:0] r, logic lst);
		mix_result_t m;
		m.kind = k; m.play_id = id; m.left = l; m.right = r; m.last = lst;
		return m;
	endfunction

	function automatic logic signed [15:0] clip(int v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	task automatic predict_mix();
		logic [31:0] el, w;
		int n, i, sl, sr, sidx;
		if (func == ssmix_pkg::FUNC_WRITE) begin
			samples[address] = {in_right, in_left};
		end else if (func == ssmix_pkg::FUNC_SCHEDULE) begin
			if (q_count >= ssmix_pkg::PEND_DEPTH_DEF) begin
				result_q.push_back(mk(ssmix_pkg::KIND_FULL, 32'd0, 16'sd0, 16'sd0, 1'b1));
			end else begin
				next_id++;
				if (next_id == 0) next_id++;
				sidx = (q_head + q_count) % ssmix_pkg::PEND_DEPTH_DEF;
				q_start[sidx] = use_now ? play_time : start_time;
				q_base[sidx] = address;
				q_len[sidx] = sound_length;
				q_id[sidx] = next_id;
				q_count++;
				result_q.push_back(mk(ssmix_pkg::KIND_ID, next_id, 16'sd0, 16'sd0, 1'b1));
			end
		end else if (func == ssmix_pkg::FUNC_BLOCK) begin
			n = 0;
			i = ch_used;
			while (i > 0 && n < ssmix_pkg::RETIRE_LIMIT) begin
				i--;
				el = play_time - ch_start[i];
				if (!el[31] && el >= ch_len[i]) begin
					result_q.push_back(mk(ssmix_pkg::KIND_DONE, ch_id[i], 16'sd0, 16'sd0,
						1'b0));
					n++;
					ch_used--;
					ch_start[i] = ch_start[ch_used];
					ch_base[i] = ch_base[ch_used];
					ch_len[i] = ch_len[ch_used];
					ch_id[i] = ch_id[ch_used];
				end
			end
			while (q_count > 0 && ch_used < ssmix_pkg::MAX_SLOTS_DEF) begin
				ch_start[ch_used] = q_start[q_head];
				ch_base[ch_used] = q_base[q_head];
				ch_len[ch_used] = q_len[q_head];
				ch_id[ch_used] = q_id[q_head];
				ch_used++;
				q_head = (q_head + 1) % ssmix_pkg::PEND_DEPTH_DEF;
				q_count--;
			end
			if (n > 0) result_q[$].last = 1'b1;
		end else begin
			sl = 0; sr = 0;
			for (i = 0; i < ch_used; i++) begin
				el = play_time - ch_start[i];
				if (!el[31] && el < ch_len[i]) begin
					sidx = (ch_base[i] + el) % ssmix_pkg::STORE_WORDS_DEF;
					w = samples.exists(sidx) ? samples[sidx] : 32'd0;
					sl += $signed(w[15:0]);
					sr += $signed(w[31:16]);
				end
			end
			result_q.push_back(mk(ssmix_pkg::KIND_MIX, 32'd0, clip(sl), clip(sr), 1'b1));
			play_time++;
		end
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		results_seen = 0;
		ch_used = 0; q_head = 0; q_count = 0;
		play_time = 0; next_id = 0;
		for (int i = 0; i < ssmix_pkg::MAX_SLOTS_DEF; i++) begin
			ch_start[i] = 0; ch_base[i] = 0; ch_len[i] = 0; ch_id[i] = 0;
		end
	end

	always @(posedge clk) begin
		mix_result_t exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (result_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d id %0d",
						kind, play_id));
				end else begin
					exp_r = result_q.pop_front();
					if (kind !== exp_r.kind || play_id !== exp_r.play_id ||
							mix_left !== exp_r.left || mix_right !== exp_r.right ||
							last !== exp_r.last)
						report_mismatch($sformatf(
							"got k%0d id%0d l%0d r%0d last%0d, want k%0d id%0d l%0d r%0d last%0d",
							kind, play_id, mix_left, mix_right, last, exp_r.kind,
							exp_r.play_id, exp_r.left, exp_r.right, exp_r.last));
				end
			end
			if (in_valid && !in_stall) predict_mix();
		end
	end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives writes, schedules, block starts and ticks into the stereo mixer with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int IDLE_LIMIT = 20000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = ssmix_pkg::FUNC_WRITE;
	logic [15:0]        address = '0;
	logic signed [15:0] in_left = '0;
	logic signed [15:0] in_right = '0;
	logic [16:0]        sound_length = '0;
	logic [31:0]        start_time = '0;
	logic               use_now = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         kind;
	logic [31:0]        play_id;
	logic signed [15:0] mix_left, mix_right;
	logic               last;
	int                 fail_count, pending, results_seen;
	int                 idle_cycles = 0;
	int                 items_sent = 0;
	int                 stall_left = 0;
	bit                 long_stalls = 1'b1;

	always #6 clk = ~clk;

	scheduled_stereo_sample_mixer_unit u_top (.*);

	ssmix_checker u_chk (.*);

	// random gap lengths: mostly short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (long_stalls && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left <= gap_len();
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired after %0d items", items_sent);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send(ssmix_pkg::func_t f, logic [15:0] a, logic [15:0] l,
			logic [15:0] r, logic [16:0] len, logic [31:0] st, logic now);
		int g;
		func <= f; address <= a; in_left <= l; in_right <= r;
		sound_length <= len; start_time <= st; use_now <= now;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
		@(negedge clk);
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic write_word(logic [15:0] a, logic [15:0] l, logic [15:0] r);
		send(ssmix_pkg::FUNC_WRITE, a, l, r, 17'($urandom), $urandom, 1'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// the random part reads back only addresses in the low region; all are written
	localparam int REGION = 48;

	initial begin
		int op, t;
		logic [15:0] b;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// fill the readable region so every sample read hits a written word
		write_word(16'h0000, 16'h7fff, 16'h8000);
		write_word(16'h0001, 16'h8000, 16'h7fff);
		for (int i = 2; i < REGION; i++)
			write_word(16'(i), 16'($urandom), 16'($urandom));
		// directed: extremes, future start, zero length, full queue, saturation
		write_word(16'hffff, 16'h7fff, 16'h7fff);
		send(ssmix_pkg::FUNC_SCHEDULE, 16'hffff, 0, 0, 17'd1, 32'd0, 1'b1);
		send(ssmix_pkg::FUNC_SCHEDULE, 16'h0000, 0, 0, 17'd0, 32'd0, 1'b1);
		send(ssmix_pkg::FUNC_SCHEDULE, 16'h0000, 0, 0, 17'd2, 32'hffff_ffff, 1'b0);
		send(ssmix_pkg::FUNC_SCHEDULE, 16'h0000, 0, 0, 17'd3, 32'd4, 1'b0);
		for (int i = 0; i < 5; i++)
			send(ssmix_pkg::FUNC_SCHEDULE, 16'h0000, 0, 0, 17'd2, 32'd0, 1'b1);
		send(ssmix_pkg::FUNC_SCHEDULE, 16'h0001, 0, 0, 17'd2, 32'd0, 1'b1);
		send(ssmix_pkg::FUNC_BLOCK, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 6; i++) send(ssmix_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0);
		send(ssmix_pkg::FUNC_BLOCK, 0, 0, 0, 0, 0, 0);
		send(ssmix_pkg::FUNC_BLOCK, 0, 0, 0, 0, 0, 0);
		drain();
		// random part: short well-formed sounds that stay inside the region
		for (int n = 0; n < 110; n++) begin
			if (n == 55) begin
				drain();
				long_stalls = 1'b0;
			end
			if (n == 80) long_stalls = 1'b1;
			op = $urandom_range(0, 99);
			if (op < 10) begin
				write_word(16'($urandom_range(0, REGION - 1)), 16'($urandom),
					16'($urandom));
			end else if (op < 40) begin
				b = 16'($urandom_range(0, REGION - 25));
				t = $urandom_range(0, 99);
				send(ssmix_pkg::FUNC_SCHEDULE, b, 16'($urandom), 16'($urandom),
					(t < 5) ? 17'd0 : 17'($urandom_range(1, 24)),
					u_chk.play_time + 32'($urandom_range(0, 8)),
					1'($urandom_range(0, 1)));
			end else if (op < 55) begin
				send(ssmix_pkg::FUNC_BLOCK, 16'($urandom), 16'($urandom), 16'($urandom),
					17'($urandom), $urandom, 1'($urandom));
			end else begin
				send(ssmix_pkg::FUNC_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
					17'($urandom), $urandom, 1'($urandom));
			end
		end
		// let the sounds run out and retire
		for (int i = 0; i < 30; i++) send(ssmix_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0);
		send(ssmix_pkg::FUNC_BLOCK, 0, 0, 0, 0, 0, 0);
		send(ssmix_pkg::FUNC_BLOCK, 0, 0, 0, 0, 0, 0);
		drain();
		repeat (200) @(negedge clk);
		$display("sent %0d transactions, checked %0d results", items_sent, results_seen);
		$display("covered writes, schedules incl. full queue, retire/admit and mixing");
		if (fail_count == 0 && pending == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule

### scheduled_stereo_sample_mixer_unit.f
src/ssmix_pkg.sv
src/scheduled_stereo_sample_mixer_unit.sv
tb/sv/ssmix_checker.sv
tb/sv/tb_top.sv
